/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers with a reset guard; empty when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_AT(name, ck, rn, prop) \
  name: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("scaler assertion failed");

`define ASSERT_NEXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("scaler assertion failed");

`else

`define ASSERT_AT(name, ck, rn, prop)

`define ASSERT_NEXT(name, ck, rn, ante, cons)

`endif

`endif

/* rtl/nsr_pkg.sv */
// ----------------------------------------------------------------------------
// Scaler package
// Shared widths, request entry type, configuration and status structs.
// ----------------------------------------------------------------------------
package nsr_pkg;

  localparam int DIM_W  = 9;
  localparam int FRAC_W = 16;
  localparam int POS_W  = 24;
  localparam int ADDR_W = 16;
  localparam int PIX_W  = 16;
  localparam int OPIX_W = 32;
  localparam int NUM_W  = DIM_W + FRAC_W;
  localparam int QDEPTH = 2;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

  localparam logic CMD_LOAD = 1'b0;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_REQ  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] index;
    logic [PIX_W-1:0]  pixel;
  } entry_t;

  typedef struct packed {
    logic [DIM_W-1:0] src_width;
    logic [DIM_W-1:0] src_height;
    logic [DIM_W-1:0] dst_width;
    logic [DIM_W-1:0] dst_height;
  } cfg_t;

  typedef struct packed {
    logic dividing;
    logic calc;
    logic reading;
    logic walk_done;
  } back_status_t;

endpackage

/* rtl/nsr_if.sv */
// ----------------------------------------------------------------------------
// Scaler channel interfaces
// Valid/ready channels for incoming commands and outgoing scaled pixels.
// ----------------------------------------------------------------------------
interface nsr_in_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [nsr_pkg::ADDR_W-1:0] load_index;
  logic [nsr_pkg::PIX_W-1:0]  src_pixel;

  modport source (output valid, output command, output load_index, output src_pixel,
                  input ready);
  modport sink (input valid, input command, input load_index, input src_pixel,
                output ready);
endinterface

interface nsr_out_if;
  logic                       valid;
  logic                       ready;
  logic [nsr_pkg::OPIX_W-1:0] out_pixel;
  logic [nsr_pkg::ADDR_W-1:0] out_index;
  logic                       last;

  modport source (output valid, output out_pixel, output out_index, output last,
                  input ready);
  modport sink (input valid, input out_pixel, input out_index, input last,
                output ready);
endinterface

/* rtl/nsr_front.sv */
// ----------------------------------------------------------------------------
// Scaler front end
// Registers each incoming request and classifies it as a load or a pixel fetch.
// ----------------------------------------------------------------------------
module nsr_front (
  input  logic             clk,
  input  logic             rst_n,
  nsr_in_if.sink           in_ch,
  output nsr_pkg::entry_t  ent,
  output logic             ent_valid,
  input  logic             ent_ready
);

  logic            hold_valid_r;
  nsr_pkg::entry_t hold_r;
  nsr_pkg::entry_t hold_nxt;
  logic            accept;

  assign in_ch.ready = !hold_valid_r || ent_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    hold_nxt.kind  = (in_ch.command == nsr_pkg::CMD_LOAD) ? nsr_pkg::KIND_LOAD
                                                          : nsr_pkg::KIND_REQ;
    hold_nxt.index = in_ch.load_index;
    hold_nxt.pixel = in_ch.src_pixel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (accept) begin
      hold_valid_r <= 1'b1;
    end else if (ent_ready) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= hold_nxt;
    end
  end

  assign ent       = hold_r;
  assign ent_valid = hold_valid_r;

endmodule

/* rtl/nsr_queue.sv */
// ----------------------------------------------------------------------------
// Scaler request queue
// Short FIFO that decouples the front end from the pixel engine.
// ----------------------------------------------------------------------------
module nsr_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  nsr_pkg::entry_t push_ent,
  input  logic            push_valid,
  output logic            push_ready,
  output nsr_pkg::entry_t head,
  output logic            head_valid,
  input  logic            pop
);

  localparam int QA_W = (nsr_pkg::QDEPTH > 1) ? $clog2(nsr_pkg::QDEPTH) : 1;
  localparam int QC_W = $clog2(nsr_pkg::QDEPTH + 1);

  nsr_pkg::entry_t mem_r [nsr_pkg::QDEPTH];
  logic [QA_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QA_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0] count_r, count_nxt;
  logic            push, pop_fire;

  assign push_ready = (count_r != QC_W'(nsr_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop_fire   = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == QA_W'(nsr_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == QA_W'(nsr_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    case ({push, pop_fire})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop_fire) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule

/* rtl/nsr_div.sv */
// ----------------------------------------------------------------------------
// Step divider
// Radix-2 restoring divider for (src << 16) / dst, saturated to the step width.
// ----------------------------------------------------------------------------
module nsr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [nsr_pkg::DIM_W-1:0]  src,
  input  logic [nsr_pkg::DIM_W-1:0]  dst,
  output logic                       done,
  output logic [nsr_pkg::POS_W-1:0]  quot
);

  localparam int NUM_W = nsr_pkg::NUM_W;
  localparam int DIM_W = nsr_pkg::DIM_W;
  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r, quo_r;
  logic [DIM_W-1:0] den_r, rem_r, rem_nxt;
  logic [DIM_W:0]   trial, diff;
  logic             ge;

  always_comb begin
    trial   = {rem_r, num_r[NUM_W-1]};
    diff    = trial - {1'b0, den_r};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= {src, {nsr_pkg::FRAC_W{1'b0}}};
      den_r <= dst;
      rem_r <= '0;
      quo_r <= '0;
      cnt_r <= CNT_W'(NUM_W - 1);
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NUM_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign quot = quo_r[NUM_W-1] ? '1 : quo_r[nsr_pkg::POS_W-1:0];

endmodule

/* rtl/nsr_back.sv */
// ----------------------------------------------------------------------------
// Scaler pixel engine
// Holds the source store and the column-major walk, and emits scaled pixels.
// ----------------------------------------------------------------------------
module nsr_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  nsr_pkg::cfg_t         cfg,
  input  nsr_pkg::entry_t       head,
  input  logic                  head_valid,
  output logic                  pop,
  output nsr_pkg::back_status_t status,
  nsr_out_if.source             out_ch
);

  localparam int DIM_W  = nsr_pkg::DIM_W;
  localparam int POS_W  = nsr_pkg::POS_W;
  localparam int ADDR_W = nsr_pkg::ADDR_W;
  localparam int PIX_W  = nsr_pkg::PIX_W;
  localparam int FRAC_W = nsr_pkg::FRAC_W;
  localparam int INT_W  = POS_W - FRAC_W;
  localparam int STORE_DEPTH = 1 << ADDR_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_CALC = 4'b0100,
    S_READ = 4'b1000
  } state_t;

  function automatic logic [nsr_pkg::OPIX_W-1:0] widen(input logic [PIX_W-1:0] p);
    widen = {p[15], 7'd0, p[14:10], 3'd0, p[9:5], 3'd0, p[4:0], 3'd0};
  endfunction

  logic [PIX_W-1:0] store_mem [STORE_DEPTH];

  state_t            state_r, state_nxt;
  logic [DIM_W-1:0]  out_col_r, out_row_r;
  logic [POS_W-1:0]  col_pos_r, row_pos_r;
  logic [POS_W-1:0]  col_step_r, row_step_r;
  logic              walk_done_r;
  logic              div_row_r;
  logic [ADDR_W-1:0] addr_r, oidx_r;
  logic              last_r;
  logic              out_valid_r;
  logic [PIX_W-1:0]  rd_r;
  logic [ADDR_W-1:0] oidx_out_r;
  logic              last_out_r;

  logic              is_load, is_req, req_ok, pass_start;
  logic              do_load, do_calc, start_col, start_row, do_read;
  logic              div_start, div_done;
  logic [DIM_W-1:0]  div_src, div_dst;
  logic [POS_W-1:0]  div_quot;
  logic [DIM_W:0]    row_inc, col_inc;
  logic              row_end, col_end;
  logic [INT_W-1:0]  col_int, row_int;
  logic [16:0]       src_prod;
  logic [17:0]       dst_prod;
  logic [ADDR_W-1:0] addr_calc, oidx_calc;

  assign is_load    = (head.kind == nsr_pkg::KIND_LOAD);
  assign is_req     = (head.kind == nsr_pkg::KIND_REQ);
  assign req_ok     = !walk_done_r && (cfg.dst_width != '0) && (cfg.dst_height != '0);
  assign pass_start = (out_col_r == '0) && (out_row_r == '0);

  assign pop       = (state_r == S_IDLE) && head_valid;
  assign do_load   = pop && is_load;
  assign start_col = pop && is_req && req_ok && pass_start;
  assign do_calc   = (pop && is_req && req_ok && !pass_start) || (state_r == S_CALC);
  assign start_row = (state_r == S_DIV) && div_done && !div_row_r;
  assign do_read   = (state_r == S_READ) && (!out_valid_r || out_ch.ready);

  assign div_start = start_col || start_row;
  assign div_src   = start_row ? cfg.src_height : cfg.src_width;
  assign div_dst   = start_row ? cfg.dst_height : cfg.dst_width;

  nsr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .src   (div_src),
    .dst   (div_dst),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    col_int   = col_pos_r[POS_W-1:FRAC_W];
    row_int   = row_pos_r[POS_W-1:FRAC_W];
    src_prod  = 17'(row_int) * 17'(cfg.src_width);
    addr_calc = src_prod[ADDR_W-1:0] + ADDR_W'(col_int);
    dst_prod  = 18'(out_row_r) * 18'(cfg.dst_width);
    oidx_calc = dst_prod[ADDR_W-1:0] + ADDR_W'(out_col_r);
    row_inc   = {1'b0, out_row_r} + 1'b1;
    col_inc   = {1'b0, out_col_r} + 1'b1;
    row_end   = (row_inc >= {1'b0, cfg.dst_height});
    col_end   = (col_inc >= {1'b0, cfg.dst_width});
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start_col) begin
          state_nxt = S_DIV;
        end else if (do_calc) begin
          state_nxt = S_READ;
        end
      end
      S_DIV: begin
        if (div_done && div_row_r) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        state_nxt = S_READ;
      end
      S_READ: begin
        if (do_read) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_col_r   <= '0;
      out_row_r   <= '0;
      col_pos_r   <= '0;
      row_pos_r   <= '0;
      col_step_r  <= '0;
      row_step_r  <= '0;
      walk_done_r <= 1'b0;
      div_row_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (do_load) begin
        out_col_r   <= '0;
        out_row_r   <= '0;
        col_pos_r   <= '0;
        row_pos_r   <= '0;
        walk_done_r <= 1'b0;
      end
      if (start_col) begin
        div_row_r <= 1'b0;
        col_pos_r <= '0;
        row_pos_r <= '0;
      end
      if ((state_r == S_DIV) && div_done) begin
        if (div_row_r) begin
          row_step_r <= div_quot;
        end else begin
          col_step_r <= div_quot;
          div_row_r  <= 1'b1;
        end
      end
      if (do_calc) begin
        if (row_end) begin
          out_row_r <= '0;
          row_pos_r <= '0;
          if (col_end) begin
            walk_done_r <= 1'b1;
            out_col_r   <= '0;
            col_pos_r   <= '0;
          end else begin
            out_col_r <= col_inc[DIM_W-1:0];
            col_pos_r <= col_pos_r + col_step_r;
          end
        end else begin
          out_row_r <= row_inc[DIM_W-1:0];
          row_pos_r <= row_pos_r + row_step_r;
        end
      end
      if (do_read) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_calc) begin
      addr_r <= addr_calc;
      oidx_r <= oidx_calc;
      last_r <= row_end && col_end;
    end
    if (do_read) begin
      oidx_out_r <= oidx_r;
      last_out_r <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      store_mem[head.index] <= head.pixel;
    end
    if (do_read) begin
      rd_r <= store_mem[addr_r];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_pixel = widen(rd_r);
  assign out_ch.out_index = oidx_out_r;
  assign out_ch.last      = last_out_r;

  always_comb begin
    status.dividing  = (state_r == S_DIV);
    status.calc      = do_calc;
    status.reading   = (state_r == S_READ);
    status.walk_done = walk_done_r;
  end

endmodule

/* rtl/nearest_scale_rgb555_to_argb8888.sv */
// ----------------------------------------------------------------------------
// Nearest-neighbor scaler, A1R5G5B5 to A8R8G8B8
// Loads a source image into a 64K-entry store and emits scaled pixels on request.
// ----------------------------------------------------------------------------
// The input channel carries requests: command 0 writes src_pixel at load_index
// and restarts the walk, command 1 asks for the next scaled pixel. The output
// channel returns the widened pixel, its destination index and a last flag.
// Pixels come out column by column, each column walked top to bottom.
// The user must set sizes through the write port only while no request is in
// flight; the block does not enforce this. A request passes the input
// register and the queue; the engine then registers the address and walk
// update and then the store read before the pixel shows at the output. The
// engine finishes the store read before it takes the next request; a load is
// written to the store as it is popped. The first fetch of each pass waits
// while the shared one-bit-per-cycle divider forms the column and row steps.
// When the receiver stalls, the finished pixel waits
// in the output register and one more fetch can be prepared behind it;
// then the queue fills and the input deasserts ready. Reset clears the walk
// and sets all sizes to MAX_DIM; the store keeps no reset value.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_scale_rgb555_to_argb8888 #(
  parameter int MAX_DIM = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  nsr_in_if.sink                        in_ch,
  nsr_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [nsr_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [nsr_pkg::DIM_W-1:0]     cfg_wdata
);

  localparam logic [nsr_pkg::DIM_W-1:0] DIM_RESET = nsr_pkg::DIM_W'(MAX_DIM);

  nsr_pkg::cfg_t         cfg_r;
  nsr_pkg::entry_t       f_ent, q_head;
  logic                  f_valid, f_ready;
  logic                  q_valid, q_pop;
  nsr_pkg::back_status_t st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_width  <= DIM_RESET;
      cfg_r.src_height <= DIM_RESET;
      cfg_r.dst_width  <= DIM_RESET;
      cfg_r.dst_height <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        nsr_pkg::REG_SRC_WIDTH:  cfg_r.src_width  <= cfg_wdata;
        nsr_pkg::REG_SRC_HEIGHT: cfg_r.src_height <= cfg_wdata;
        nsr_pkg::REG_DST_WIDTH:  cfg_r.dst_width  <= cfg_wdata;
        nsr_pkg::REG_DST_HEIGHT: cfg_r.dst_height <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  nsr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .ent       (f_ent),
    .ent_valid (f_valid),
    .ent_ready (f_ready)
  );

  nsr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_ent   (f_ent),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .head       (q_head),
    .head_valid (q_valid),
    .pop        (q_pop)
  );

  nsr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (q_head),
    .head_valid (q_valid),
    .pop        (q_pop),
    .status     (st),
    .out_ch     (out_ch)
  );

  `ASSERT_AT(a_out_from_read, clk, rst_n, $rose(out_ch.valid) |-> $past(st.reading))
  `ASSERT_AT(a_no_pop_in_div, clk, rst_n, st.dividing |-> !q_pop)
  `ASSERT_AT(a_done_from_calc, clk, rst_n, $rose(st.walk_done) |-> $past(st.calc))
  `ASSERT_NEXT(a_front_holds, clk, rst_n, f_valid && !f_ready, f_valid)

endmodule

/* dv/nsr_scaler_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scaler checker
// Watches the request, pixel and size-write ports and keeps its own copy of
// the source image, the sizes and the column-major walk. Each accepted
// request that should make a pixel adds one expected pixel. Each pixel taken
// from the output is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module nsr_scaler_checker
  import nsr_pkg::*;
#(
  parameter int MAX_DIM = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  nsr_in_if                    in_ch,
  nsr_out_if                   out_ch,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata,
  output int                   mismatches,
  output int                   pixels_owed,
  output int                   pixels_predicted
);

  typedef struct packed {
    logic [OPIX_W-1:0] pixel;
    logic [ADDR_W-1:0] index;
    logic              last;
  } scaled_pixel_t;

  scaled_pixel_t    owed_q[$];
  logic [PIX_W-1:0] image [0:(1 << ADDR_W) - 1];
  cfg_t             sizes;
  logic [DIM_W-1:0] col_count, row_count;
  logic [POS_W-1:0] col_pos, row_pos, col_inc, row_inc;
  logic             finished;

  function automatic logic [POS_W-1:0] scale_step(logic [DIM_W-1:0] src,
                                                  logic [DIM_W-1:0] dst);
    logic [NUM_W-1:0] ratio;
    ratio = {src, {FRAC_W{1'b0}}} / NUM_W'(dst);
    return (ratio > NUM_W'({POS_W{1'b1}})) ? {POS_W{1'b1}} : ratio[POS_W-1:0];
  endfunction

  task automatic restart_walk();
    col_count = '0;
    row_count = '0;
    col_pos = '0;
    row_pos = '0;
    finished = 1'b0;
  endtask

  always @(posedge clk) begin : model
    scaled_pixel_t    want;
    logic [PIX_W-1:0] src;
    int unsigned      src_addr;
    if (!rst_n) begin
      sizes = '{DIM_W'(MAX_DIM), DIM_W'(MAX_DIM), DIM_W'(MAX_DIM), DIM_W'(MAX_DIM)};
      col_inc = '0;
      row_inc = '0;
      restart_walk();
      owed_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SRC_WIDTH:  sizes.src_width = cfg_wdata;
          REG_SRC_HEIGHT: sizes.src_height = cfg_wdata;
          REG_DST_WIDTH:  sizes.dst_width = cfg_wdata;
          REG_DST_HEIGHT: sizes.dst_height = cfg_wdata;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.command == KIND_LOAD) begin
          image[in_ch.load_index] = in_ch.src_pixel;
          restart_walk();
        end else if (!finished && sizes.dst_width != 0 && sizes.dst_height != 0) begin
          if (col_count == 0 && row_count == 0) begin
            col_inc = scale_step(sizes.src_width, sizes.dst_width);
            row_inc = scale_step(sizes.src_height, sizes.dst_height);
            col_pos = '0;
            row_pos = '0;
          end
          src_addr = 32'(row_pos[POS_W-1:FRAC_W]) * 32'(sizes.src_width)
                     + 32'(col_pos[POS_W-1:FRAC_W]);
          src = image[src_addr[ADDR_W-1:0]];
          want = '0;
          want.pixel[31] = src[15];
          want.pixel[23:19] = src[14:10];
          want.pixel[15:11] = src[9:5];
          want.pixel[7:3] = src[4:0];
          want.index = ADDR_W'(32'(row_count) * 32'(sizes.dst_width) + 32'(col_count));
          if (32'(row_count) + 1 >= 32'(sizes.dst_height)) begin
            row_count = '0;
            row_pos = '0;
            if (32'(col_count) + 1 >= 32'(sizes.dst_width)) begin
              want.last = 1'b1;
              finished = 1'b1;
              col_count = '0;
              col_pos = '0;
            end else begin
              col_count = col_count + 1'b1;
              col_pos = col_pos + col_inc;
            end
          end else begin
            row_count = row_count + 1'b1;
            row_pos = row_pos + row_inc;
          end
          owed_q.push_back(want);
          pixels_predicted++;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (owed_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected pixel, expected none, got pixel %h index %h last %b",
                   $time, out_ch.out_pixel, out_ch.out_index, out_ch.last);
        end else begin
          want = owed_q.pop_front();
          if (out_ch.out_pixel !== want.pixel) begin
            mismatches++;
            $display("%0t: pixel mismatch, expected %h, got %h",
                     $time, want.pixel, out_ch.out_pixel);
          end
          if (out_ch.out_index !== want.index) begin
            mismatches++;
            $display("%0t: index mismatch, expected %h, got %h",
                     $time, want.index, out_ch.out_index);
          end
          if (out_ch.last !== want.last) begin
            mismatches++;
            $display("%0t: last mismatch, expected %b, got %b",
                     $time, want.last, out_ch.last);
          end
        end
      end
    end
    pixels_owed = owed_q.size();
  end

endmodule

/* dv/nearest_scale_rgb555_to_argb8888_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Nearest-neighbor scaler testbench
// Loads source images of many sizes, sets output sizes from zero to the
// largest, and requests scaled pixels under varying sender gaps and receiver
// stalls. Loads and size changes also land in the middle of a pass. The
// checker beside the block predicts every pixel and counts mismatches.
// ----------------------------------------------------------------------------
module nearest_scale_rgb555_to_argb8888_test;
  import nsr_pkg::*;

  localparam int RUN_LIMIT    = 1000000;
  localparam int DRAIN_CYCLES = 80;
  localparam int ITEM_GOAL    = 600;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_wdata;

  nsr_in_if  in_ch ();
  nsr_out_if out_ch ();

  int          mismatches, pixels_owed, pixels_predicted;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int          loads_sent = 0;
  bit          loaded [0:(1 << ADDR_W) - 1];
  int unsigned reg_value [4];

  nearest_scale_rgb555_to_argb8888 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  nsr_scaler_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ch            (in_ch),
    .out_ch           (out_ch),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .mismatches       (mismatches),
    .pixels_owed      (pixels_owed),
    .pixels_predicted (pixels_predicted)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("nearest_scale_rgb555_to_argb8888_test: FAIL");
    $finish;
  end

  task automatic send_item(kind_t kind, logic [ADDR_W-1:0] idx, logic [PIX_W-1:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= kind;
    in_ch.load_index <= idx;
    in_ch.src_pixel <= pix;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    if (kind == KIND_LOAD) begin
      loaded[idx] = 1'b1;
      loads_sent++;
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pixels_owed != 0);
  endtask

  task automatic settle();
    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[DIM_W-1:0];
    reg_value[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned dw, int unsigned dh);
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
  endtask

  // The first entry is always written so that every image load restarts the walk.
  task automatic load_image(int unsigned reload_odds);
    int unsigned area;
    area = reg_value[REG_SRC_WIDTH] * reg_value[REG_SRC_HEIGHT];
    for (int unsigned i = 0; i < area; i++) begin
      if (i == 0 || !loaded[i] || $urandom_range(reload_odds - 1) == 0) begin
        send_item(KIND_LOAD, ADDR_W'(i), PIX_W'($urandom));
      end
    end
  endtask

  task automatic request_run(int unsigned n, int unsigned noise_pct);
    int unsigned area;
    for (int unsigned i = 0; i < n; i++) begin
      area = reg_value[REG_SRC_WIDTH] * reg_value[REG_SRC_HEIGHT];
      if ($urandom_range(99) < noise_pct) begin
        if ($urandom_range(1) == 0) begin
          send_item(KIND_LOAD, ADDR_W'($urandom_range(area - 1)), PIX_W'($urandom));
        end else begin
          send_item(KIND_LOAD, ADDR_W'($urandom), PIX_W'($urandom));
        end
      end else begin
        send_item(KIND_REQ, ADDR_W'($urandom), PIX_W'($urandom));
      end
    end
  endtask

  initial begin
    int unsigned          sw, sh, dw, dh, n_req, half, lo;
    logic [REG_IDX_W-1:0] pick;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.command = KIND_LOAD;
    in_ch.load_index = '0;
    in_ch.src_pixel = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_sizes(2, 2, 3, 2);
    send_item(KIND_LOAD, 16'd0, 16'h0000);
    send_item(KIND_LOAD, 16'd1, 16'hFFFF);
    send_item(KIND_LOAD, 16'd2, 16'h8000);
    send_item(KIND_LOAD, 16'd3, 16'h7FFF);
    send_item(KIND_LOAD, 16'hFFFF, 16'hAAAA);
    request_run(8, 0);
    drain();
    send_item(KIND_LOAD, 16'd3, 16'h5555);
    request_run(3, 0);
    send_item(KIND_LOAD, 16'd0, 16'h1234);
    request_run(2, 0);
    settle();
    write_reg(REG_DST_HEIGHT, 0);
    request_run(2, 0);

    for (int phase = 0; phase < 8 || loads_sent + pixels_predicted < ITEM_GOAL; phase++) begin
      sw = $urandom_range(1, 16);
      sh = $urandom_range(1, 16);
      dw = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 24);
      dh = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 24);
      case (phase)
        0: begin
          sw = 256;
          sh = 1;
          dw = 1;
          dh = $urandom_range(1, 8);
        end
        1: begin
          sw = 1;
          sh = 256;
          dw = $urandom_range(1, 8);
          dh = 1;
        end
        2: begin
          dw = 256;
          dh = 1;
        end
        3: begin
          dw = 1;
          dh = 256;
        end
        4: begin
          dw = 0;
          dh = 256;
        end
        default: ;
      endcase
      settle();
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 70;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 70;
        end
        default: begin
          send_idle_pct = 27;
          stall_pct = 27;
        end
      endcase
      set_sizes(sw, sh, dw, dh);
      load_image((sw * sh > 64) ? 16 : 4);
      n_req = $urandom_range(8, 40);
      half = $urandom_range(n_req);
      request_run(half, 8);
      if ($urandom_range(2) == 0) begin
        drain();
      end
      request_run(n_req - half, 8);
      // Sizes never grow inside a pass so that no unwritten source entry is read.
      if ($urandom_range(1) == 0) begin
        settle();
        pick = REG_IDX_W'($urandom_range(3));
        lo = (pick == REG_DST_WIDTH || pick == REG_DST_HEIGHT) ? 0 : 1;
        write_reg(pick, $urandom_range(lo, reg_value[pick]));
        request_run($urandom_range(4, 12), 8);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("nearest_scale_rgb555_to_argb8888_test: PASS");
    end else begin
      $display("nearest_scale_rgb555_to_argb8888_test: FAIL");
    end
    $finish;
  end

endmodule
